// ===== rtl/core/sha_pkg.sv =====
// SHA-256 shared package: round constants, initial hash, queue entry type.
// Used by sha_front, sha_back and sha256_stream_hasher. No dependencies.
`timescale 1ns / 1ps
package sha_pkg;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } item_t;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int unsigned LEN_POS = 56;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

endpackage

// ===== rtl/core/sha_front.sv =====
// Front end: input stream accept and a two-entry word queue toward the back end.
// Depends on sha_pkg.
`timescale 1ns / 1ps
module sha_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,
  input  logic               s_tuser,
  output logic               q_valid,
  input  logic               q_ready,
  output sha_pkg::item_t     q_item
);

  sha_pkg::item_t slot [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;
  logic           pop;

  assign s_tready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = slot[rd_ptr];
  assign push     = s_tvalid && s_tready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr].kind      <= s_tuser;
      slot[wr_ptr].data_byte <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== rtl/core/sha_back.sv =====
// Back end: block words in the schedule window, padding, 64-round compression,
// digest output register. Depends on sha_pkg.
`timescale 1ns / 1ps
module sha_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_ready,
  input  sha_pkg::item_t q_item,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [31:0]    m_tdata,
  output logic [2:0]     m_tuser,
  output logic           m_tlast
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PAD   = 6'b000010,
    ST_ROUND = 6'b000100,
    ST_ADD   = 6'b001000,
    ST_EMIT  = 6'b010000,
    ST_LEN   = 6'b100000
  } state_t;

  state_t       state;
  logic [5:0]   fill;
  logic [63:0]  total;
  logic [31:0]  chain [8];
  logic [31:0]  v [8];
  logic [31:0]  w [16];
  logic [5:0]   round;
  logic         finishing;
  logic         last_block;
  logic [2:0]   out_idx;

  logic [31:0]  w_new;
  logic [31:0]  s0;
  logic [31:0]  s1;
  logic [31:0]  ch;
  logic [31:0]  mj;
  logic [31:0]  t1;
  logic [31:0]  t2;
  logic [31:0]  x0;
  logic [31:0]  x1;
  logic [3:0]   ri;
  logic [63:0]  bits;

  assign q_ready = (state == ST_IDLE);
  assign ri      = round[3:0];
  assign bits    = {total[60:0], 3'b000};

  always_comb begin
    x0 = sha_pkg::rotr(w[ri + 4'd1], 7) ^ sha_pkg::rotr(w[ri + 4'd1], 18) ^
         (w[ri + 4'd1] >> 3);
    x1 = sha_pkg::rotr(w[ri + 4'd14], 17) ^ sha_pkg::rotr(w[ri + 4'd14], 19) ^
         (w[ri + 4'd14] >> 10);
    if (round < 6'd16) begin
      w_new = w[ri];
    end else begin
      w_new = w[ri] + x0 + w[ri + 4'd9] + x1;
    end
    s1 = sha_pkg::rotr(v[4], 6) ^ sha_pkg::rotr(v[4], 11) ^ sha_pkg::rotr(v[4], 25);
    ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1 = v[7] + s1 + ch + sha_pkg::ROUND_K[round] + w_new;
    s0 = sha_pkg::rotr(v[0], 2) ^ sha_pkg::rotr(v[0], 13) ^ sha_pkg::rotr(v[0], 22);
    mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2 = s0 + mj;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= 6'd0;
      total     <= 64'd0;
      round     <= 6'd0;
      finishing <= 1'b0;
      last_block <= 1'b0;
      out_idx   <= 3'd0;
      m_tvalid  <= 1'b0;
      for (int i = 0; i < 8; i++) chain[i] <= sha_pkg::INIT_HASH[i];
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            if (q_item.kind == sha_pkg::KIND_DATA) begin
              w[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= q_item.data_byte;
              fill         <= fill + 6'd1;
              total        <= total + 64'd1;
              if (fill == 6'd63) begin
                finishing  <= 1'b0;
                last_block <= 1'b0;
                round      <= 6'd0;
                for (int i = 0; i < 8; i++) v[i] <= chain[i];
                state      <= ST_ROUND;
              end
            end else begin
              w[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= sha_pkg::PAD_BYTE;
              fill         <= fill + 6'd1;
              finishing    <= 1'b1;
              last_block   <= 1'b0;
              state        <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          // zero fill one byte a cycle up to the length field or block end
          if (fill == 6'd0 && !last_block) begin
            round      <= 6'd0;
            for (int i = 0; i < 8; i++) v[i] <= chain[i];
            state      <= ST_ROUND;
          end else if (fill == 6'(sha_pkg::LEN_POS)) begin
            state <= ST_LEN;
          end else begin
            w[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= 8'h00;
            fill         <= fill + 6'd1;
          end
        end
        ST_LEN: begin
          w[14]      <= bits[63:32];
          w[15]      <= bits[31:0];
          last_block <= 1'b1;
          round      <= 6'd0;
          for (int i = 0; i < 8; i++) v[i] <= chain[i];
          state      <= ST_ROUND;
        end
        ST_ROUND: begin
          w[ri] <= w_new;
          v[7] <= v[6];
          v[6] <= v[5];
          v[5] <= v[4];
          v[4] <= v[3] + t1;
          v[3] <= v[2];
          v[2] <= v[1];
          v[1] <= v[0];
          v[0] <= t1 + t2;
          round <= round + 6'd1;
          if (round == 6'd63) state <= ST_ADD;
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) chain[i] <= chain[i] + v[i];
          fill <= 6'd0;
          if (!finishing) begin
            state <= ST_IDLE;
          end else if (last_block) begin
            out_idx  <= 3'd0;
            m_tvalid <= 1'b1;
            state    <= ST_EMIT;
          end else begin
            // pad spilled: next block holds only zeros and the length
            last_block <= 1'b1;
            state      <= ST_PAD;
          end
        end
        ST_EMIT: begin
          if (m_tready) begin
            if (out_idx == 3'd7) begin
              m_tvalid  <= 1'b0;
              finishing <= 1'b0;
              fill      <= 6'd0;
              total     <= 64'd0;
              for (int i = 0; i < 8; i++) chain[i] <= sha_pkg::INIT_HASH[i];
              state     <= ST_IDLE;
            end
            out_idx <= out_idx + 3'd1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tdata = chain[out_idx];
  assign m_tuser = out_idx;
  assign m_tlast = (out_idx == 3'd7);

endmodule

// ===== rtl/core/sha256_stream_hasher.sv =====
// SHA-256 streaming hasher, top level.
// Input words carry one message byte or an end-of-message mark; output
// words carry the eight digest words after each end mark.
// Front end queues input words; back end buffers, pads and compresses.
// A data word is written into the block buffer; the 64th byte of a block starts
// the 64 compression rounds (one round a cycle) and the chain update.
// An end mark writes the pad byte, zero fills at one byte a cycle up to the
// length field, places the length and compresses. When the pad spills past
// byte 55, the spilled block first zero fills to its end and is compressed;
// a second block of zeros and the length is then compressed.
// Then 8 digest words follow, one per accepted cycle.
// Reset restores the initial hash and empties the buffer and queue.
// If the receiver stalls, the current digest word holds; the two-entry
// queue keeps accepting input until it fills.
// Depends on sha_pkg, sha_front, sha_back.
`timescale 1ns / 1ps
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // digest_word
  output logic [2:0]  m_tuser,   // word_index
  output logic        m_tlast    // last_word
);

  logic           q_valid;
  logic           q_ready;
  sha_pkg::item_t q_item;

  sha_front u_front (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  sha_back u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

endmodule

// ===== verif/sha256_stream_checker.sv =====
// Digest checker for sha256_stream_hasher: watches both stream sides, hashes
// accepted bytes with its own SHA-256 model and compares every digest word.
// Depends on sha_pkg for the kind codes and round/initial constants.
`timescale 1ns / 1ps
module sha256_stream_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic [2:0]  m_tuser,
  input  logic        m_tlast,
  output int          errors,
  output int          pending,
  output int          words_seen,
  output int          digests_seen
);

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  digest_word_t exp_words[$];
  logic [31:0]  hash_state [8];
  logic [7:0]   blk [64];
  int unsigned  fill;
  logic [63:0]  msg_bytes;

  function automatic logic [31:0] ror(logic [31:0] v, int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int r = 0; r < 16; r++)
      w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
    for (int r = 16; r < 64; r++)
      w[r] = w[r-16] + (ror(w[r-15], 7) ^ ror(w[r-15], 18) ^ (w[r-15] >> 3))
           + w[r-7] + (ror(w[r-2], 17) ^ ror(w[r-2], 19) ^ (w[r-2] >> 10));
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
    e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
    for (int r = 0; r < 64; r++) begin
      t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
         + sha_pkg::ROUND_K[r] + w[r];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
    hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
  endtask

  task automatic restart();
    for (int i = 0; i < 8; i++) hash_state[i] = sha_pkg::INIT_HASH[i];
    fill = 0;
    msg_bytes = '0;
  endtask

  task automatic absorb(logic kind, logic [7:0] b);
    logic [63:0] bits;
    digest_word_t dw;
    if (kind == sha_pkg::KIND_DATA) begin
      blk[fill] = b;
      fill++;
      msg_bytes++;
      if (fill == 64) begin
        compress();
        fill = 0;
      end
    end else begin
      bits = msg_bytes << 3;
      blk[fill] = 8'h80;
      fill++;
      if (fill > 56) begin
        for (int i = fill; i < 64; i++) blk[i] = 8'h00;
        compress();
        fill = 0;
      end
      for (int i = fill; i < 56; i++) blk[i] = 8'h00;
      for (int i = 0; i < 8; i++) blk[63-i] = bits[8*i +: 8];
      compress();
      for (int i = 0; i < 8; i++) begin
        dw.word = hash_state[i];
        dw.idx  = 3'(i);
        dw.last = (i == 7);
        exp_words.push_back(dw);
      end
      restart();
    end
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %0s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
    words_seen = 0;
    digests_seen = 0;
    restart();
  end

  always @(posedge clk) begin
    digest_word_t e;
    if (rst) begin
      exp_words.delete();
      restart();
    end else begin
      if (m_tvalid && m_tready) begin
        words_seen++;
        if (m_tlast) digests_seen++;
        if (exp_words.size() == 0) begin
          report("unexpected word", m_tdata, 32'h0);
        end else begin
          e = exp_words.pop_front();
          if (m_tdata !== e.word) report("digest word", m_tdata, e.word);
          if (m_tuser !== e.idx) report("word index", 32'(m_tuser), 32'(e.idx));
          if (m_tlast !== e.last) report("last flag", 32'(m_tlast), 32'(e.last));
        end
      end
      if (s_tvalid && s_tready) absorb(s_tuser, s_tdata);
    end
    pending = exp_words.size();
  end
endmodule

// ===== verif/tb_sha256_stream_hasher.sv =====
// Testbench top for sha256_stream_hasher: drives byte/end words with random
// gaps and output stalls; sha256_stream_checker predicts and compares.
// Depends on sha_pkg, the hasher RTL and verif/sha256_stream_checker.sv.
`timescale 1ns / 1ps
module tb_sha256_stream_hasher;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tuser = sha_pkg::KIND_DATA;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;
  int          errors, pending, words_seen, digests_seen;
  int          cycles = 0;
  bit          calm = 1'b0;
  int          sent = 0;
  int          longest = 0;

  localparam int LIMIT = 400000;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sha256_stream_hasher DUT (.*);

  sha256_stream_checker u_chk (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[sha256_stream_hasher] ERROR");
      $finish;
    end
  end

  // receiver stalls in bursts
  initial begin
    int n;
    @(negedge clk);
    while (1) begin
      m_tready <= 1'b1;
      n = $urandom_range(1, 30);
      repeat (n) @(negedge clk);
      if (!calm && $urandom_range(0, 1)) begin
        m_tready <= 1'b0;
        n = $urandom_range(1, 17);
        repeat (n) @(negedge clk);
      end
    end
  end

  // called and returns at a falling edge; s_tvalid stays high afterwards
  task automatic send_word(logic kind, logic [7:0] b);
    int n;
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      n = $urandom_range(1, 17);
      repeat (n) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= b;
    while (!s_tready) @(negedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_message(int len, int pattern, logic [7:0] end_byte);
    for (int i = 0; i < len; i++)
      case (pattern)
        0: send_word(sha_pkg::KIND_DATA, 8'h00);
        1: send_word(sha_pkg::KIND_DATA, 8'hff);
        default: send_word(sha_pkg::KIND_DATA, 8'($urandom_range(0, 255)));
      endcase
    send_word(sha_pkg::KIND_END, end_byte);
    if (len > longest) longest = len;
  endtask

  initial begin
    int len;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // directed: empty, four bytes with byte extremes, one byte, end with nonzero data field
    send_message(0, 2, 8'hff);
    send_word(sha_pkg::KIND_DATA, 8'h00);
    send_word(sha_pkg::KIND_DATA, 8'hff);
    send_word(sha_pkg::KIND_DATA, 8'h5a);
    send_word(sha_pkg::KIND_DATA, 8'ha5);
    send_word(sha_pkg::KIND_END, 8'h00);
    send_message(1, 1, 8'h80);
    // hold off until all digests drain
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    // one full block, then 63 bytes so the pad byte closes the second block
    send_message(127, 2, 8'h00);
    // short random messages with no idling to finish
    calm = 1'b1;
    while (sent < 145) begin
      len = $urandom_range(0, 4);
      send_message(len, 2, 8'($urandom_range(0, 255)));
    end
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    $display("covered %0d input words, %0d digests (%0d words), longest message %0d bytes",
             sent, digests_seen, words_seen, longest);
    if (errors == 0 && pending == 0) begin
      $display("[sha256_stream_hasher] OK");
    end else begin
      $display("[sha256_stream_hasher] ERROR");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/core/sha_pkg.sv
rtl/core/sha_front.sv
rtl/core/sha_back.sv
rtl/core/sha256_stream_hasher.sv
verif/sha256_stream_checker.sv
verif/tb_sha256_stream_hasher.sv
